>>> rtl/ascii_attitude_frame_parser_defines.svh
// assertion macros shared by the attitude frame parser
`ifndef ASCII_ATTITUDE_FRAME_PARSER_DEFINES_SVH
`define ASCII_ATTITUDE_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define AAFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define AAFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/aafp_pkg.sv
// types and constants of the attitude frame parser
package aafp_pkg;

  localparam int VAL_W = 24;
  localparam int CNT_W = 7;
  localparam int ACC_W = 28;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] TAG_ROLL  = 32'h524C_4C3A;
  localparam logic [31:0] TAG_PITCH = 32'h5043_483A;
  localparam logic [31:0] TAG_YAW   = 32'h5941_573A;

  localparam logic [1:0] FLD_NONE  = 2'd0;
  localparam logic [1:0] FLD_ROLL  = 2'd1;
  localparam logic [1:0] FLD_PITCH = 2'd2;
  localparam logic [1:0] FLD_YAW   = 2'd3;

  localparam logic [1:0] FRAC_ENDED = 2'd3;

  localparam logic [1:0] REG_MIN_LEN = 2'd0;

  localparam logic [ACC_W-1:0] LIM_POS = 28'd8388607;
  localparam logic [ACC_W-1:0] LIM_NEG = 28'd8388608;

  localparam logic [CNT_W-1:0] MIN_LEN_RST = 7'd32;
  localparam logic [7:0]       CLOSE_SLACK = 8'd2;

  typedef struct packed {
    logic [1:0]       active;
    logic [VAL_W-1:0] acc;
    logic             neg;
    logic             point;
    logic [1:0]       frac;
  } field_st_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] roll;
    logic signed [VAL_W-1:0] pitch;
    logic signed [VAL_W-1:0] yaw;
    logic [2:0]              found;
  } result_t;

endpackage

>>> rtl/aafp_value_step.sv
// one byte of decimal value parsing for the active field
module aafp_value_step (
  input  logic [7:0]         byte_in,
  input  logic               after_colon,
  input  aafp_pkg::field_st_t cur,
  output aafp_pkg::field_st_t nxt,
  output logic               comma
);
  import aafp_pkg::*;

  logic [3:0]       digit;
  logic [ACC_W-1:0] acc_w;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] lim;
  logic             is_digit;

  assign digit    = byte_in[3:0];
  assign acc_w    = {{(ACC_W-VAL_W){1'b0}}, cur.acc};
  assign lim      = cur.neg ? LIM_NEG : LIM_POS;
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);

  always_comb begin
    mag = acc_w;
    if (!cur.point) begin
      mag = (acc_w << 3) + (acc_w << 1) + ACC_W'(digit) * ACC_W'(100);
    end else begin
      case (cur.frac)
        2'd0: mag = acc_w + ACC_W'(digit) * ACC_W'(10);
        2'd1: mag = acc_w + ACC_W'(digit);
        default: mag = acc_w;
      endcase
    end
    if (mag > lim) begin
      mag = lim;
    end
  end

  always_comb begin
    nxt   = cur;
    comma = 1'b0;
    if (cur.active != FLD_NONE) begin
      if (byte_in == CH_COMMA) begin
        comma = 1'b1;
      end else if (cur.frac != FRAC_ENDED) begin
        if (is_digit) begin
          nxt.acc = mag[VAL_W-1:0];
          if (cur.point && cur.frac == 2'd0) begin
            nxt.frac = 2'd1;
          end else if (cur.point && cur.frac == 2'd1) begin
            nxt.frac = 2'd2;
          end
        end else if (byte_in == CH_POINT && !cur.point) begin
          nxt.point = 1'b1;
        end else if ((byte_in == CH_PLUS || byte_in == CH_MINUS) && after_colon) begin
          nxt.neg = (byte_in == CH_MINUS);
        end else begin
          nxt.frac = FRAC_ENDED;
        end
      end
    end
  end

endmodule

>>> rtl/aafp_core.sv
// frame hunting, tag matching and field registers
module aafp_core #(
  parameter int MAX_PAYLOAD = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [7:0]                    byte_in,
  input  logic [aafp_pkg::CNT_W-1:0]    min_len,
  output logic                          closing,
  output logic                          res_fire,
  output aafp_pkg::result_t             res
);
  import aafp_pkg::*;
  `include "ascii_attitude_frame_parser_defines.svh"

  logic [1:0]       marker_run;
  logic             in_frame;
  logic [CNT_W-1:0] payload_count;
  logic [31:0]      tag_window;
  field_st_t        fld;
  logic [2:0]       found_mask;
  logic [VAL_W-1:0] field_values [3];

  field_st_t        step_nxt;
  field_st_t        fld_next;
  logic             step_comma;
  logic             after_colon;
  logic [31:0]      window_next;
  logic             close;
  logic             abandon;
  logic             tag_hit;
  logic [1:0]       tag_idx;
  logic             commit;
  logic [1:0]       commit_idx;
  logic [VAL_W-1:0] commit_val;
  logic [VAL_W-1:0] cur_fin;

  assign after_colon = (tag_window[7:0] == CH_COLON);
  assign window_next = {tag_window[23:0], byte_in};

  aafp_value_step u_step (
    .byte_in     (byte_in),
    .after_colon (after_colon),
    .cur         (fld),
    .nxt         (step_nxt),
    .comma       (step_comma)
  );

  always_comb begin
    tag_hit = 1'b1;
    tag_idx = 2'd0;
    if (window_next == TAG_ROLL) begin
      tag_idx = 2'd0;
    end else if (window_next == TAG_PITCH) begin
      tag_idx = 2'd1;
    end else if (window_next == TAG_YAW) begin
      tag_idx = 2'd2;
    end else begin
      tag_hit = 1'b0;
    end
  end

  always_comb begin
    fld_next = step_nxt;
    if (tag_hit) begin
      if (found_mask[tag_idx]) begin
        fld_next.active = FLD_NONE;
      end else begin
        fld_next        = '0;
        fld_next.active = tag_idx + 2'd1;
      end
    end else if (step_comma) begin
      fld_next.active = FLD_NONE;
    end
  end

  assign commit     = (step_nxt.active != FLD_NONE) && (step_comma || tag_hit);
  assign commit_idx = step_nxt.active - 2'd1;
  assign commit_val = step_nxt.neg ? (VAL_W'(0) - step_nxt.acc) : step_nxt.acc;
  assign cur_fin    = fld.neg ? (VAL_W'(0) - fld.acc) : fld.acc;

  assign close = in_frame && (byte_in == CH_STAR) && (marker_run >= 2'd2) &&
                 ({1'b0, payload_count} >= ({1'b0, min_len} + CLOSE_SLACK));
  assign abandon = in_frame && !close && (payload_count >= CNT_W'(MAX_PAYLOAD));

  assign closing   = close;
  assign res_fire  = go && close;
  assign res.roll  = (fld.active == FLD_ROLL)  ? cur_fin : field_values[0];
  assign res.pitch = (fld.active == FLD_PITCH) ? cur_fin : field_values[1];
  assign res.yaw   = (fld.active == FLD_YAW)   ? cur_fin : field_values[2];
  assign res.found = found_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_run      <= '0;
      in_frame        <= 1'b0;
      payload_count   <= '0;
      tag_window      <= '0;
      fld             <= '0;
      found_mask      <= '0;
      field_values[0] <= '0;
      field_values[1] <= '0;
      field_values[2] <= '0;
    end else if (go) begin
      if (!in_frame || close || abandon) begin
        payload_count   <= '0;
        tag_window      <= '0;
        fld             <= '0;
        found_mask      <= '0;
        field_values[0] <= '0;
        field_values[1] <= '0;
        field_values[2] <= '0;
      end
      if (!in_frame) begin
        if (byte_in == CH_BANG) begin
          if (marker_run == 2'd2) begin
            marker_run <= '0;
            in_frame   <= 1'b1;
          end else begin
            marker_run <= marker_run + 2'd1;
          end
        end else begin
          marker_run <= '0;
        end
      end else if (close || abandon) begin
        marker_run <= '0;
        in_frame   <= 1'b0;
      end else begin
        payload_count <= payload_count + CNT_W'(1);
        if (byte_in == CH_STAR) begin
          marker_run <= (marker_run == 2'd3) ? 2'd3 : marker_run + 2'd1;
        end else begin
          marker_run <= '0;
        end
        tag_window <= window_next;
        if (commit) begin
          field_values[commit_idx] <= commit_val;
        end
        if (tag_hit && !found_mask[tag_idx]) begin
          found_mask[tag_idx] <= 1'b1;
        end
        fld <= fld_next;
      end
    end
  end

  `AAFP_ASSERT_IMP(a_hunt_clear, !in_frame,
    (payload_count == '0) && (fld.active == FLD_NONE) && (found_mask == '0),
    "frame state not cleared while hunting")
  `AAFP_ASSERT_IMP(a_hunt_run, !in_frame, marker_run != 2'd3,
    "open marker run out of range")
  `AAFP_ASSERT_IMP(a_count_bound, in_frame, payload_count <= CNT_W'(MAX_PAYLOAD),
    "payload count past bound")
  `AAFP_ASSERT_NEXT(a_close_ends, res_fire, !in_frame,
    "frame still open after close")

endmodule

>>> rtl/ascii_attitude_frame_parser.sv
// top level: config register, input register, parser core and result register
// a closing item's path: input register, parser core, result register
// throughput: one item per cycle, limited by the single byte-wide state update,
// but a waiting result holds back a closing item; others keep flowing
// reset (synchronous): hunting for an open marker, min_payload_len back to 32
module ascii_attitude_frame_parser #(
  parameter int MAX_PAYLOAD = 100
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [23:0]         roll_centi,
  output logic signed [23:0]         pitch_centi,
  output logic signed [23:0]         yaw_centi,
  output logic                       roll_found,
  output logic                       pitch_found,
  output logic                       yaw_found,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import aafp_pkg::*;

  logic [CNT_W-1:0] min_payload_len;
  logic [7:0]       rx_q;
  logic             rx_q_valid;
  logic             proc;
  logic             closing;
  logic             res_fire;
  result_t          res;
  result_t          res_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_LEN) ? {{(32-CNT_W){1'b0}}, min_payload_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_payload_len <= MIN_LEN_RST;
    end else if (psel && penable && pwrite) begin
      min_payload_len <= pwdata[CNT_W-1:0];
    end
  end

  assign proc     = rx_q_valid && (!closing || !out_valid || out_ready);
  assign in_ready = !rx_q_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      rx_q_valid <= 1'b1;
    end else if (proc) begin
      rx_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_q <= rx_byte;
    end
  end

  aafp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (proc),
    .byte_in  (rx_q),
    .min_len  (min_payload_len),
    .closing  (closing),
    .res_fire (res_fire),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_q <= res;
    end
  end

  assign roll_centi  = res_q.roll;
  assign pitch_centi = res_q.pitch;
  assign yaw_centi   = res_q.yaw;
  assign roll_found  = res_q.found[0];
  assign pitch_found = res_q.found[1];
  assign yaw_found   = res_q.found[2];

endmodule
